>>> src/tci_pkg.sv
// shared constants, types and cosine table builder for the interpolated table cosine
package tci_pkg;

  localparam int TABLE_LOG2_SIZE = 10;
  localparam int OUT_FRAC_BITS   = 16;

  localparam int TABLE_SIZE = 1 << TABLE_LOG2_SIZE;
  localparam int ANGLE_W    = 32;
  localparam int PHASE_W    = 32;
  localparam int IDX_W      = TABLE_LOG2_SIZE;
  localparam int ADDR_W     = TABLE_LOG2_SIZE + 1;
  localparam int FRAC_W     = PHASE_W - TABLE_LOG2_SIZE;
  localparam int COS_W      = OUT_FRAC_BITS + 2;
  localparam int DIFF_W     = COS_W + 1;
  localparam int PROD_W     = DIFF_W + FRAC_W + 1;
  localparam int BASE_W     = COS_W + FRAC_W + 2;

  // turns = |angle| * 1/(2*pi); only bits 47:16 of the sum are kept
  localparam int SUM_W   = PHASE_W + 16;
  localparam int SUM_LSB = 16;

  localparam logic [31:0] INV_TWO_PI_HI = 32'h28BE60DB;
  localparam logic [31:0] INV_TWO_PI_LO = 32'h9391054A;
  localparam logic [63:0] TWO_PI_Q60    = 64'h6487ED5110B4611A;
  localparam logic [63:0] Q60_ONE       = 64'h1 << 60;

  localparam logic signed [COS_W-1:0] COS_ONE     = COS_W'(1 << OUT_FRAC_BITS);
  localparam logic signed [COS_W-1:0] COS_NEG_ONE = -COS_ONE;

  typedef logic signed [COS_W-1:0] cos_rom_t [TABLE_SIZE+1];

  // one load enable per pipeline stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  // (a * b) >> s over the full 128-bit product
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int unsigned s);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return 64'(p >> s);
  endfunction

  // floor(n / d) by shift and subtract, d small and nonzero
  function automatic logic [63:0] div_floor(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // taylor series in q60 for a in [0, pi/2)
  function automatic logic signed [63:0] taylor_q60(logic [63:0] a, logic want_sin);
    logic        [63:0] a2;
    logic        [63:0] t;
    logic        [63:0] d;
    logic signed [63:0] sum;
    a2  = mul_shift(a, a, 60);
    t   = want_sin ? a : Q60_ONE;
    sum = signed'(t);
    for (int k = 1; k <= 24; k++) begin
      d = want_sin ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
      t = div_floor(mul_shift(t, a2, 60), d);
      if (k % 2 == 1) begin
        sum = sum - signed'(t);
      end else begin
        sum = sum + signed'(t);
      end
    end
    return sum;
  endfunction

  function automatic logic signed [COS_W-1:0] build_sample(logic [63:0] i);
    int unsigned        qs;
    logic        [63:0] q;
    logic        [63:0] r;
    logic        [63:0] a;
    logic signed [63:0] v;
    logic               neg;
    logic        [63:0] mag;
    logic        [63:0] m;
    qs  = TABLE_LOG2_SIZE - 2;
    q   = (i >> qs) & 64'd3;
    r   = i & ((64'd1 << qs) - 64'd1);
    a   = (r == 64'd0) ? 64'd0 : mul_shift(TWO_PI_Q60, r, TABLE_LOG2_SIZE);
    v   = taylor_q60(a, q[0]);
    neg = (q == 64'd1) || (q == 64'd2);
    if (v < 0) begin
      neg = !neg;
      mag = 64'(-v);
    end else begin
      mag = 64'(v);
    end
    m = (mag + (64'd1 << (59 - OUT_FRAC_BITS))) >> (60 - OUT_FRAC_BITS);
    if (m > (64'd1 << OUT_FRAC_BITS)) begin
      m = 64'd1 << OUT_FRAC_BITS;
    end
    return neg ? COS_W'(-m) : COS_W'(m);
  endfunction

  function automatic cos_rom_t build_rom();
    cos_rom_t rom;
    for (int i = 0; i <= TABLE_SIZE; i++) begin
      rom[i] = build_sample(64'(i));
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_rom();

endpackage

>>> src/tci_angle_if.sv
// input channel carrying one angle per beat
interface tci_angle_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tci_pkg::ANGLE_W-1:0]     angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

>>> src/tci_cosine_if.sv
// output channel carrying one cosine per beat
interface tci_cosine_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tci_pkg::COS_W-1:0]     cosine;

  modport source (output valid, output cosine, input ready);
  modport sink (input valid, input cosine, output ready);
endinterface

>>> src/tci_phase.sv
// angle to turn-fraction conversion: magnitude, two products, then the phase sum
module tci_phase (
  input  logic                              clk,
  input  tci_pkg::stage_en_t                en,
  input  logic signed [tci_pkg::ANGLE_W-1:0] angle,
  output logic [tci_pkg::IDX_W-1:0]         idx,
  output logic [tci_pkg::FRAC_W-1:0]        frac
);

  logic [tci_pkg::ANGLE_W-1:0] mag;
  logic [tci_pkg::SUM_W-1:0]   p_hi;
  logic [31:0]                 p_lo;
  logic [tci_pkg::SUM_W-1:0]   sum;
  logic [tci_pkg::PHASE_W-1:0] phase;
  logic [63:0]                 prod_hi;
  logic [63:0]                 prod_lo;

  // most negative angle gives exactly 2^31 as an unsigned magnitude
  assign mag     = angle[tci_pkg::ANGLE_W-1] ? (~angle + 1'b1) : angle;
  assign prod_hi = {32'b0, mag} * {32'b0, tci_pkg::INV_TWO_PI_HI};
  assign prod_lo = {32'b0, mag} * {32'b0, tci_pkg::INV_TWO_PI_LO};

  always_ff @(posedge clk) begin
    if (en.s1) begin
      p_hi <= prod_hi[tci_pkg::SUM_W-1:0];
      p_lo <= prod_lo[63:32];
    end
  end

  assign sum = p_hi + {{(tci_pkg::SUM_W-32){1'b0}}, p_lo};

  always_ff @(posedge clk) begin
    if (en.s2) begin
      phase <= sum[tci_pkg::SUM_LSB +: tci_pkg::PHASE_W];
    end
  end

  assign idx  = phase[tci_pkg::PHASE_W-1 -: tci_pkg::IDX_W];
  assign frac = phase[tci_pkg::FRAC_W-1:0];

endmodule

>>> src/tci_rom.sv
// cosine sample rom, two synchronous read ports
module tci_rom (
  input  logic                              clk,
  input  logic                              en,
  input  logic [tci_pkg::ADDR_W-1:0]        addr_a,
  input  logic [tci_pkg::ADDR_W-1:0]        addr_b,
  output logic signed [tci_pkg::COS_W-1:0]  data_a,
  output logic signed [tci_pkg::COS_W-1:0]  data_b
);

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= tci_pkg::COS_ROM[addr_a];
      data_b <= tci_pkg::COS_ROM[addr_b];
    end
  end

endmodule

>>> src/tci_interp.sv
// linear interpolation between adjacent samples, floor to output precision
module tci_interp (
  input  logic                              clk,
  input  tci_pkg::stage_en_t                en,
  input  logic [tci_pkg::FRAC_W-1:0]        frac,
  input  logic signed [tci_pkg::COS_W-1:0]  left,
  input  logic signed [tci_pkg::COS_W-1:0]  right,
  output logic signed [tci_pkg::COS_W-1:0]  cosine
);

  logic        [tci_pkg::FRAC_W-1:0]  frac3;
  logic signed [tci_pkg::DIFF_W-1:0]  diff;
  logic signed [tci_pkg::PROD_W-1:0]  prod;
  logic signed [tci_pkg::COS_W-1:0]   left4;
  logic signed [tci_pkg::PROD_W-1:0]  prod4;
  logic signed [tci_pkg::BASE_W-1:0]  base;

  // frac travels alongside the rom read
  always_ff @(posedge clk) begin
    if (en.s3) begin
      frac3 <= frac;
    end
  end

  assign diff = tci_pkg::DIFF_W'(right) - tci_pkg::DIFF_W'(left);
  assign prod = tci_pkg::PROD_W'(diff) * signed'({1'b0, frac3});

  always_ff @(posedge clk) begin
    if (en.s4) begin
      left4 <= left;
      prod4 <= prod;
    end
  end

  assign base = (tci_pkg::BASE_W'(left4) <<< tci_pkg::FRAC_W) + tci_pkg::BASE_W'(prod4);

  // taking the upper bits is a floor division
  always_ff @(posedge clk) begin
    if (en.s5) begin
      cosine <= base[tci_pkg::FRAC_W +: tci_pkg::COS_W];
    end
  end

endmodule

>>> src/table_cosine_interpolated.sv
// interpolated table cosine: top level with pipeline handshake
//
// angle_ch takes one signed q16.16 angle in radians per beat; cosine_ch
// returns its cosine as signed q1.16 (65536 is 1.0), one beat per angle,
// in order. the angle magnitude is scaled by 1/(2*pi) to a 32-bit turn
// fraction, whose top bits address a 1025-entry cosine rom and whose low
// bits interpolate between neighbouring samples.
// pipeline stages, from an accepted angle to a valid cosine:
//   stage 1  magnitude and the two 32x32 products with 1/(2*pi)
//   stage 2  phase sum (turn fraction)
//   stage 3  rom read of both neighbouring samples
//   stage 4  difference times fraction
//   stage 5  add and floor, output register
// throughput is one beat per cycle when cosine_ch is ready; each stage
// loads whenever it is empty or the stage after it moves on, so bubbles
// close up while the receiver stalls and a full pipeline holds five
// beats. ready on angle_ch is high whenever the output register is empty.
// reset empties every stage; the rom contents are fixed at build and need
// no fill pass, so angles are taken from the first cycle after reset.
module table_cosine_interpolated (
  input  logic          clk,
  input  logic          rst,
  tci_angle_if.sink     angle_ch,
  tci_cosine_if.source  cosine_ch
);

  localparam int STAGES = 5;

  logic [STAGES:1]                   vld;
  logic [STAGES:1]                   rdy;
  tci_pkg::stage_en_t                en;
  logic [tci_pkg::IDX_W-1:0]         idx;
  logic [tci_pkg::FRAC_W-1:0]        frac;
  logic [tci_pkg::ADDR_W-1:0]        addr_a;
  logic [tci_pkg::ADDR_W-1:0]        addr_b;
  logic signed [tci_pkg::COS_W-1:0]  left;
  logic signed [tci_pkg::COS_W-1:0]  right;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    rdy[STAGES] = !vld[STAGES] || cosine_ch.ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= angle_ch.valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign en.s1 = rdy[1];
  assign en.s2 = rdy[2];
  assign en.s3 = rdy[3];
  assign en.s4 = rdy[4];
  assign en.s5 = rdy[5];

  assign angle_ch.ready  = rdy[1];
  assign cosine_ch.valid = vld[STAGES];

  tci_phase u_phase (
    .clk   (clk),
    .en    (en),
    .angle (angle_ch.angle),
    .idx   (idx),
    .frac  (frac)
  );

  // the last segment reads entry TABLE_SIZE, which equals entry zero
  assign addr_a = {1'b0, idx};
  assign addr_b = {1'b0, idx} + 1'b1;

  tci_rom u_rom (
    .clk    (clk),
    .en     (en.s3),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .data_a (left),
    .data_b (right)
  );

  tci_interp u_interp (
    .clk    (clk),
    .en     (en),
    .frac   (frac),
    .left   (left),
    .right  (right),
    .cosine (cosine_ch.cosine)
  );

  // with the output register empty nothing upstream can be blocked
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !cosine_ch.valid |-> angle_ch.ready)
    else $error("angle channel stalled with an empty output register");

  // interpolation between samples in [-1, 1] stays in [-1, 1]
  a_cosine_in_range: assert property (@(posedge clk) disable iff (rst)
    cosine_ch.valid |-> (cosine_ch.cosine <= tci_pkg::COS_ONE) &&
                        (cosine_ch.cosine >= tci_pkg::COS_NEG_ONE))
    else $error("cosine outside unit range");

  // a blocked rom stage keeps its beat
  a_rom_stage_holds: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !rdy[4] |=> vld[3] && $stable(left) && $stable(right))
    else $error("rom stage lost its beat while blocked");

endmodule

>>> sim/tb.sv
// interpolated table cosine testbench: corner and random angles checked against a predictor
`timescale 1ns / 1ps

module tb;
  import tci_pkg::*;

  // 1/(2*pi) as a q0.64 fraction, truncated
  localparam logic [63:0] TURNS_PER_RADIAN = 64'h28BE60DB9391054A;
  // 2*pi and 1.0 in q60, used when building the sample table
  localparam logic [63:0] TWO_PI_Q60_C = 64'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q60      = 64'h1 << 60;

  localparam int CORNER_COUNT = 16;
  localparam int RANDOM_BEATS = 1750;
  localparam int QUIET_TAIL   = 250;
  localparam int DRAIN_CYCLES = 20;

  // expected cosines, one per accepted angle, in arrival order
  class cosine_scoreboard;
    logic signed [COS_W-1:0] samples [TABLE_SIZE+1];
    logic signed [COS_W-1:0] awaited_cos [$];
    int                      errors;

    function new();
      errors = 0;
      for (int i = 0; i <= TABLE_SIZE; i++) begin
        samples[i] = cos_sample(i);
      end
    endfunction

    // low 64 bits of (x * y) >> 60
    function automatic logic [63:0] q60_mul(logic [63:0] x, logic [63:0] y);
      logic [127:0] p;
      p = x;
      p = p * y;
      return p[123:60];
    endfunction

    // one table entry: cos(2*pi*i/size) in q1.16, nearest, ties away from zero
    function automatic logic signed [COS_W-1:0] cos_sample(int unsigned i);
      logic        [1:0]   quad;
      logic        [63:0]  r;
      logic        [127:0] wide;
      logic        [63:0]  a;
      logic        [63:0]  a2;
      logic        [63:0]  term;
      logic        [63:0]  mag;
      logic        [63:0]  m;
      logic signed [63:0]  acc;
      logic                odd;
      logic                neg;
      quad = 2'(i >> (TABLE_LOG2_SIZE - 2));
      r    = 64'(i & ((1 << (TABLE_LOG2_SIZE - 2)) - 1));
      wide = TWO_PI_Q60_C;
      wide = wide * r;
      a    = wide[TABLE_LOG2_SIZE +: 64];
      odd  = quad[0];
      a2   = q60_mul(a, a);
      // odd quadrants use the sine series on the offset within the quadrant
      term = odd ? a : ONE_Q60;
      acc  = signed'(term);
      for (int k = 1; k <= 24; k++) begin
        term = q60_mul(term, a2) / (odd ? 64'((2 * k) * (2 * k + 1))
                                        : 64'((2 * k - 1) * (2 * k)));
        if (k % 2 == 1) begin
          acc = acc - signed'(term);
        end else begin
          acc = acc + signed'(term);
        end
      end
      neg = (quad == 2'd1) || (quad == 2'd2);
      if (acc < 0) begin
        neg = !neg;
        mag = 64'(-acc);
      end else begin
        mag = 64'(acc);
      end
      m = (mag + (64'd1 << (59 - OUT_FRAC_BITS))) >> (60 - OUT_FRAC_BITS);
      if (m > (64'd1 << OUT_FRAC_BITS)) begin
        m = 64'd1 << OUT_FRAC_BITS;
      end
      return neg ? COS_W'(-m) : COS_W'(m);
    endfunction

    function void note_angle(logic signed [ANGLE_W-1:0] ang);
      logic        [ANGLE_W-1:0] mag;
      logic        [95:0]        turns;
      logic        [PHASE_W-1:0] phase;
      int unsigned               seg;
      logic        [FRAC_W-1:0]  frac;
      logic signed [63:0]        lo;
      logic signed [63:0]        hi;
      logic signed [63:0]        base;
      // the most negative angle keeps a magnitude of exactly 2^31
      mag   = ang[ANGLE_W-1] ? ANGLE_W'(-ang) : ang;
      turns = mag;
      turns = turns * TURNS_PER_RADIAN;
      // whole turns fall away, which wraps the angle modulo 2*pi
      phase = turns[79:48];
      seg   = phase[PHASE_W-1:FRAC_W];
      frac  = phase[FRAC_W-1:0];
      lo    = samples[seg];
      hi    = samples[seg+1];
      base  = (lo <<< FRAC_W) + (hi - lo) * signed'({1'b0, frac});
      awaited_cos.push_back(COS_W'(base >>> FRAC_W));
    endfunction

    function void check_cosine(logic signed [COS_W-1:0] got);
      logic signed [COS_W-1:0] want;
      if (awaited_cos.size() == 0) begin
        $display("%0t cosine with none awaited: expected none, actual %0d", $time, got);
        errors++;
      end else begin
        want = awaited_cos.pop_front();
        if (got !== want) begin
          $display("%0t cosine mismatch: expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic quiet;
  int   stall_left;

  cosine_scoreboard sb;

  tci_angle_if  angle_ch ();
  tci_cosine_if cosine_ch ();

  table_cosine_interpolated dut (
    .clk       (clk),
    .rst       (rst),
    .angle_ch  (angle_ch),
    .cosine_ch (cosine_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // angles that hit the edges: zero, the field extremes, the most negative
  // angle, multiples of pi/2, and either side of a full turn (the top entry
  // of the table is the neighbour of the last segment)
  logic signed [ANGLE_W-1:0] corners [CORNER_COUNT] = '{
    0, 1, -1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
    65536, -65536, 102944, 205887, -205887, 308831,
    411774, 411775, 32'sh55555555, 32'shAAAAAAAA
  };

  // receiver: ready drops in bursts of random length; no burst starts in the quiet tail
  always @(posedge clk) begin
    if (rst) begin
      cosine_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      cosine_ch.ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      cosine_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 10);
    end else begin
      cosine_ch.ready <= 1'b1;
    end
  end

  // beats are noted and checked where they are accepted; an angle always
  // goes in before its cosine comes out
  always @(posedge clk) begin
    if (!rst) begin
      if (angle_ch.valid && angle_ch.ready) begin
        sb.note_angle(angle_ch.angle);
      end
      if (cosine_ch.valid && cosine_ch.ready) begin
        sb.check_cosine(cosine_ch.cosine);
      end
    end
  end

  // offer one angle, after an optional gap, and return once it is taken
  task automatic send_angle(input logic signed [ANGLE_W-1:0] ang);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      angle_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    angle_ch.valid <= 1'b1;
    angle_ch.angle <= ang;
    @(posedge clk);
    while (!angle_ch.ready) @(posedge clk);
  endtask

  // random angle: full range, up to two turns either way, or close to a
  // multiple of pi/2 where the table changes quadrant
  function automatic logic signed [ANGLE_W-1:0] random_angle();
    logic signed [ANGLE_W-1:0] ang;
    int unsigned               pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      ang = $urandom();
    end else if (pick < 8) begin
      ang = $urandom_range(0, 823550);
    end else begin
      ang = $urandom_range(0, 7) * 102944 + $urandom_range(0, 8) - 4;
    end
    if (pick >= 4 && $urandom_range(0, 1) == 1) begin
      ang = -ang;
    end
    return ang;
  endfunction

  initial begin
    rst             = 1'b1;
    quiet           = 1'b0;
    angle_ch.valid  = 1'b0;
    angle_ch.angle  = '0;
    cosine_ch.ready = 1'b0;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (corners[i]) begin
      send_angle(corners[i]);
    end

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // the tail runs at full rate on both sides
      if (n == RANDOM_BEATS - QUIET_TAIL) begin
        quiet = 1'b1;
      end
      send_angle(random_angle());
    end
    angle_ch.valid <= 1'b0;

    while (sb.awaited_cos.size() > 0) @(posedge clk);
    // run on so that any stray beat is caught
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.awaited_cos.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
src/tci_pkg.sv
src/tci_angle_if.sv
src/tci_cosine_if.sv
src/tci_phase.sv
src/tci_rom.sv
src/tci_interp.sv
src/table_cosine_interpolated.sv
sim/tb.sv
